// File: src/prast_pkg.sv
// Package: shared types, constants and function codes for the primitive rasterizer.
package prast_pkg;
  localparam int COORD_W = 12;
  localparam int COLOR_W = 16;
  localparam int FRAC_W  = 16;

  localparam logic [2:0] FN_TICK    = 3'd0;
  localparam logic [2:0] FN_HSPAN   = 3'd1;
  localparam logic [2:0] FN_VSPAN   = 3'd2;
  localparam logic [2:0] FN_LINE    = 3'd3;
  localparam logic [2:0] FN_OUTLINE = 3'd4;
  localparam logic [2:0] FN_FILL    = 3'd5;

  typedef struct packed {
    logic [2:0]         func;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [COLOR_W-1:0] color;
  } in_word_t;

  typedef struct packed {
    logic [COORD_W:0]   px;
    logic [COORD_W:0]   py;
    logic [COLOR_W-1:0] pcolor;
    logic               last_pixel;
  } out_word_t;
endpackage

// File: src/prast_queue.sv
// Two-entry word queue between the front and back parts.
module prast_queue import prast_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  in_word_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output in_word_t rd_data
);
  in_word_t  mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  logic      wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
endmodule

// File: src/prast_front.sv
// Front part: drops unused function codes before the queue.
module prast_front import prast_pkg::*; (
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output in_word_t q_data
);
  logic keep;
  assign keep     = (in_data.func <= FN_FILL);
  assign in_ready = q_ready || !keep;
  assign q_valid  = in_valid && keep;
  assign q_data   = in_data;
endmodule

// File: src/prast_back.sv
// Back part: primitive setup, DDA divider and pixel walker with output register.
module prast_back import prast_pkg::*; #(
  parameter int COORD_BITS = COORD_W,
  parameter int COLOR_BITS = COLOR_W,
  parameter int FRAC_BITS  = FRAC_W
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  output logic     q_ready,
  input  in_word_t q_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_word_t out_data
);
  localparam int CW = COORD_BITS;
  localparam int PW = CW + 1 + FRAC_BITS;
  localparam int SW = FRAC_BITS + 2;
  localparam int DW = CW + FRAC_BITS;
  localparam int NW = $clog2(DW + 1);
  localparam logic [2:0] M_IDLE = 3'd0, M_WALK = 3'd1, M_OUTLINE = 3'd2,
                         M_FILL = 3'd3, M_DIV = 3'd4;
  localparam logic [SW-1:0] ONE = SW'(1) << FRAC_BITS;

  logic [2:0]      mode_r, mode_nxt;
  logic [1:0]      ph_r, ph_nxt;
  logic [PW-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic [SW-1:0]   sx_r, sx_nxt, sy_r, sy_nxt;
  logic [CW:0]     rem_r, rem_nxt;
  logic [CW-1:0]   ox_r, ox_nxt, oy_r, oy_nxt, w_r, w_nxt, h_r, h_nxt;
  logic [COLOR_BITS-1:0] col_r, col_nxt;
  // divider
  logic [DW-1:0]   dnum_r, dnum_nxt;
  logic [CW:0]     drem_r, drem_nxt;
  logic [DW-1:0]   dq_r, dq_nxt;
  logic [NW-1:0]   dcnt_r, dcnt_nxt;
  logic            dxneg_r, dxneg_nxt, dyneg_r, dyneg_nxt, dsel_r, dsel_nxt;
  out_word_t       ob_r, ob_nxt;
  logic            ov_r, ov_nxt;

  logic [CW-1:0] ax, ay, bx, by, adx, ady, big, sml;
  logic          take, dxn, dyn;
  logic [CW:0]   dtry;
  logic [SW-1:0] zero_s;

  assign ax = CW'(q_data.ax);
  assign ay = CW'(q_data.ay);
  assign bx = CW'(q_data.bx);
  assign by = CW'(q_data.by);
  assign dxn = bx < ax;
  assign dyn = by < ay;
  assign adx = dxn ? ax - bx : bx - ax;
  assign ady = dyn ? ay - by : by - ay;
  assign big = (adx > ady) ? adx : ady;
  assign sml = (adx > ady) ? ady : adx;
  assign zero_s = '0;

  assign q_ready  = (mode_r != M_DIV) && (!ov_r || out_ready);
  assign take     = q_valid && q_ready;
  assign out_valid = ov_r;
  assign out_data  = ob_r;
  assign dtry = {drem_r[CW-1:0], dnum_r[DW-1]} - {1'b0, rem_r[CW-1:0]};

  always_comb begin
    mode_nxt = mode_r; ph_nxt = ph_r; x_nxt = x_r; y_nxt = y_r;
    sx_nxt = sx_r; sy_nxt = sy_r; rem_nxt = rem_r; ox_nxt = ox_r; oy_nxt = oy_r;
    w_nxt = w_r; h_nxt = h_r; col_nxt = col_r;
    dnum_nxt = dnum_r; drem_nxt = drem_r; dq_nxt = dq_r; dcnt_nxt = dcnt_r;
    dxneg_nxt = dxneg_r; dyneg_nxt = dyneg_r; dsel_nxt = dsel_r;
    ob_nxt = ob_r; ov_nxt = ov_r && !out_ready;
    if (mode_r == M_DIV) begin
      // restoring divide: (sml << FRAC) / big, one bit per cycle
      if (!dtry[CW]) begin
        drem_nxt = dtry;
        dq_nxt = {dq_r[DW-2:0], 1'b1};
      end else begin
        drem_nxt = {drem_r[CW-1:0], dnum_r[DW-1]};
        dq_nxt = {dq_r[DW-2:0], 1'b0};
      end
      dnum_nxt = {dnum_r[DW-2:0], 1'b0};
      dcnt_nxt = dcnt_r - 1'b1;
      if (dcnt_r == NW'(1)) begin
        mode_nxt = M_WALK;
        if (dsel_r) begin
          sx_nxt = dxneg_r ? zero_s - ONE : ONE;
          sy_nxt = dyneg_r ? zero_s - SW'(dq_nxt) : SW'(dq_nxt);
        end else begin
          sy_nxt = dyneg_r ? zero_s - ONE : ONE;
          sx_nxt = dxneg_r ? zero_s - SW'(dq_nxt) : SW'(dq_nxt);
        end
      end
    end else if (take) begin
      if (q_data.func != FN_TICK) begin
        col_nxt = COLOR_BITS'(q_data.color);
        ph_nxt = 2'd0;
        mode_nxt = M_IDLE;
        sx_nxt = '0; sy_nxt = '0;
        case (q_data.func)
          FN_HSPAN: begin
            if (bx > ax) begin
              x_nxt = PW'(ax) << FRAC_BITS; y_nxt = PW'(ay) << FRAC_BITS;
              sx_nxt = ONE; rem_nxt = {1'b0, bx - ax}; mode_nxt = M_WALK;
            end
          end
          FN_VSPAN: begin
            if (by > ay) begin
              x_nxt = PW'(ax) << FRAC_BITS; y_nxt = PW'(ay) << FRAC_BITS;
              sy_nxt = ONE; rem_nxt = {1'b0, by - ay}; mode_nxt = M_WALK;
            end
          end
          FN_LINE: begin
            x_nxt = PW'(ax) << FRAC_BITS; y_nxt = PW'(ay) << FRAC_BITS;
            if (ax == bx) begin
              if (by > ay) begin
                sy_nxt = ONE; rem_nxt = {1'b0, by - ay}; mode_nxt = M_WALK;
              end
            end else if (ay == by) begin
              if (bx > ax) begin
                sx_nxt = ONE; rem_nxt = {1'b0, bx - ax}; mode_nxt = M_WALK;
              end
            end else begin
              rem_nxt = {1'b0, big};
              dsel_nxt = (adx > ady);
              dxneg_nxt = dxn; dyneg_nxt = dyn;
              dnum_nxt = DW'(sml) << FRAC_BITS;
              drem_nxt = '0; dq_nxt = '0;
              dcnt_nxt = NW'(DW);
              mode_nxt = M_DIV;
            end
          end
          FN_OUTLINE: begin
            ox_nxt = ax; oy_nxt = ay; w_nxt = bx; h_nxt = by;
            x_nxt = PW'(ax) << FRAC_BITS;
            if (bx != '0) begin
              y_nxt = PW'(ay) << FRAC_BITS; sx_nxt = ONE;
              rem_nxt = {1'b0, bx}; ph_nxt = 2'd0; mode_nxt = M_OUTLINE;
            end else if (by != '0) begin
              y_nxt = PW'(ay) << FRAC_BITS; sy_nxt = ONE;
              rem_nxt = {1'b0, by}; ph_nxt = 2'd2; mode_nxt = M_OUTLINE;
            end
          end
          FN_FILL: begin
            ox_nxt = ax; oy_nxt = ay; w_nxt = bx; h_nxt = by >> 2;
            if (bx != '0 && (by >> 2) != '0) begin
              x_nxt = PW'(ax) << FRAC_BITS; y_nxt = PW'(ay) << FRAC_BITS;
              sy_nxt = ONE; rem_nxt = {1'b0, by >> 2}; mode_nxt = M_FILL;
            end
          end
          default: ;
        endcase
      end else if (mode_r == M_IDLE || rem_r == '0) begin
        mode_nxt = M_IDLE;
      end else begin
        ov_nxt = 1'b1;
        ob_nxt.px = (COORD_W+1)'(x_r >> FRAC_BITS);
        ob_nxt.py = (COORD_W+1)'(y_r >> FRAC_BITS);
        ob_nxt.pcolor = COLOR_W'(col_r);
        ob_nxt.last_pixel = 1'b0;
        x_nxt = x_r + {{(PW-SW){sx_r[SW-1]}}, sx_r};
        y_nxt = y_r + {{(PW-SW){sy_r[SW-1]}}, sy_r};
        rem_nxt = rem_r - 1'b1;
        if (rem_r == (CW+1)'(1)) begin
          ob_nxt.last_pixel = 1'b1;
          mode_nxt = M_IDLE;
          if (mode_r == M_OUTLINE) begin
            sx_nxt = '0; sy_nxt = '0;
            if (ph_r == 2'd0 && w_r != '0) begin
              ph_nxt = 2'd1; x_nxt = PW'(ox_r) << FRAC_BITS;
              y_nxt = PW'({1'b0, oy_r} + {1'b0, h_r}) << FRAC_BITS;
              sx_nxt = ONE; rem_nxt = {1'b0, w_r};
              ob_nxt.last_pixel = 1'b0; mode_nxt = M_OUTLINE;
            end else if (ph_r != 2'd3 && h_r != '0) begin
              ph_nxt = 2'd2; x_nxt = PW'(ox_r) << FRAC_BITS;
              y_nxt = PW'(oy_r) << FRAC_BITS; sy_nxt = ONE; rem_nxt = {1'b0, h_r};
              if (ph_r == 2'd2) begin
                ph_nxt = 2'd3;
                x_nxt = PW'({1'b0, ox_r} + {1'b0, w_r}) << FRAC_BITS;
              end
              ob_nxt.last_pixel = 1'b0; mode_nxt = M_OUTLINE;
            end
          end else if (mode_r == M_FILL) begin
            w_nxt = w_r - 1'b1;
            if (w_r != CW'(1)) begin
              x_nxt = (x_r + (PW'(1) << FRAC_BITS)) & ~((PW'(1) << FRAC_BITS) - 1'b1);
              y_nxt = PW'(oy_r) << FRAC_BITS; rem_nxt = {1'b0, h_r};
              ob_nxt.last_pixel = 1'b0; mode_nxt = M_FILL;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; ph_r <= '0; rem_r <= '0; ov_r <= 1'b0; dcnt_r <= '0;
      x_r <= '0; y_r <= '0; sx_r <= '0; sy_r <= '0;
      ox_r <= '0; oy_r <= '0; w_r <= '0; h_r <= '0; col_r <= '0;
    end else begin
      mode_r <= mode_nxt; ph_r <= ph_nxt; rem_r <= rem_nxt; ov_r <= ov_nxt;
      dcnt_r <= dcnt_nxt;
      x_r <= x_nxt; y_r <= y_nxt; sx_r <= sx_nxt; sy_r <= sy_nxt;
      ox_r <= ox_nxt; oy_r <= oy_nxt; w_r <= w_nxt; h_r <= h_nxt; col_r <= col_nxt;
    end
    dnum_r <= dnum_nxt; drem_r <= drem_nxt; dq_r <= dq_nxt;
    dxneg_r <= dxneg_nxt; dyneg_r <= dyneg_nxt; dsel_r <= dsel_nxt;
    ob_r <= ob_nxt;
  end
endmodule

// File: src/primitive_rasterizer.sv
// Top level: primitive rasterizer, front filter, word queue and pixel back end.
//   channel | dir | word       | handshake
//   in_     | in  | in_word_t  | in_valid / in_ready
//   out_    | out | out_word_t | out_valid / out_ready
// Mid-walk, a tick word yields one pixel: one per cycle unless output stalls.
// A sloped line command holds the back end in the divider, one quotient bit
// per cycle, COORD_BITS + FRAC_BITS bits in all.
// Reset is synchronous on rst_n and clears queue and walker state.
// The two-entry queue lets the front keep taking words while the back stalls.
module primitive_rasterizer import prast_pkg::*; #(
  parameter int COORD_BITS = COORD_W,
  parameter int COLOR_BITS = COLOR_W,
  parameter int FRAC_BITS  = FRAC_W
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);
  logic     fq_valid, fq_ready, qb_valid, qb_ready;
  in_word_t fq_data, qb_data;

  prast_front u_front (
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );
  prast_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );
  prast_back #(.COORD_BITS(COORD_BITS), .COLOR_BITS(COLOR_BITS),
               .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped under stall");
  a_bad_func: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_data.func > FN_FILL |-> in_ready)
    else $error("unused code stalled");
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    qb_ready && !qb_valid |=> !out_valid || $past(out_valid))
    else $error("result without queued word");
endmodule
